// ===== hw/rtl/swa_pkg.sv =====
package swa_pkg;

    // Width of the time step register (unsigned Q8.16)
    localparam int TS_W = 24;

    // Width of slab times inside the lanes; room for the infinite marks
    localparam int TW = 42;

    // Split point of the ray direction for the contact multiply
    localparam int SPLIT = 28;

    // Slab time used for an axis that limits nothing
    localparam logic signed [TW-1:0] T_INF = 42'sd1099511627776;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // Contact normal codes
    localparam logic signed [1:0] NRM_ZERO = 2'sb00;
    localparam logic signed [1:0] NRM_POS  = 2'sb01;
    localparam logic signed [1:0] NRM_NEG  = 2'sb11;

    // What one axis lane reports to the merge stage
    typedef struct packed {
        logic                 ok;    // slab can be entered
        logic                 vz;    // velocity on this axis is zero
        logic                 dneg;  // ray direction is negative
        logic signed [TW-1:0] tn;    // near time
        logic signed [TW-1:0] tf;    // far time
    } t_slab;

endpackage

// ===== hw/rtl/swa_div.sv =====
module swa_div #(
    parameter int NW = 26,
    parameter int DW = 48,
    parameter int DS = 32
) (
    input  logic                 i_clk,
    input  logic [DS+NW:0]       i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic signed [31:0]   o_quo
);
    import swa_pkg::*;

    localparam int STEPS = NW + DS;

    logic [NW-1:0] r_m   [STEPS+1];
    logic [DW-1:0] r_d   [STEPS+1];
    logic [DW-1:0] r_rem [STEPS+1];
    logic [30:0]   r_q   [STEPS+1];
    logic          r_ovf [STEPS+1];
    logic          r_neg [STEPS+1];

    logic [NW-1:0] n_m;
    logic [DW-1:0] n_d;

    // Take magnitudes and the result sign
    always_comb begin
        n_m = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        n_d = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_m[0]   <= n_m;
            r_d[0]   <= n_d;
            r_neg[0] <= (i_num != '0) && (i_num[NW-1] != i_den[DW-1]);
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_ovf[0] <= 1'b0;
        end
    end

    // One quotient bit per stage; bits above 2^30 only set the overflow flag
    genvar k;
    for (k = 0; k < STEPS; k++) begin : g_step
        logic          bit_in;
        logic [DW-1:0] sh;
        logic          ge;

        if (k < NW) begin : g_num
            assign bit_in = r_m[k][NW-1-k];
        end else begin : g_pad
            assign bit_in = 1'b0;
        end

        always_comb begin
            sh = {r_rem[k][DW-2:0], bit_in};
            ge = (sh >= r_d[k]);
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k+1]) begin
                r_m[k+1]   <= r_m[k];
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
                r_rem[k+1] <= ge ? sh - r_d[k] : sh;
                r_q[k+1]   <= {r_q[k][29:0], ge};
                r_ovf[k+1] <= r_ovf[k] | r_q[k][30];
            end
        end
    end

    // Apply sign, round toward minus infinity, saturate
    logic signed [31:0] mag;
    always_comb begin
        mag = {1'b0, r_q[STEPS]};
        if (r_neg[STEPS]) begin
            o_quo = r_ovf[STEPS] ? S32_MIN : -(mag + 32'(r_rem[STEPS] != '0));
        end else begin
            o_quo = r_ovf[STEPS] ? S32_MAX : mag;
        end
    end

endmodule

// ===== hw/rtl/swa_lane.sv =====
module swa_lane #(
    parameter int CW  = 24,
    parameter int TFB = 16
) (
    input  logic                                 i_clk,
    input  logic [CW+TFB+20:0]                   i_en,
    input  logic signed [CW-1:0]                 i_pos,
    input  logic [CW-2:0]                        i_size,
    input  logic signed [CW-1:0]                 i_vel,
    input  logic signed [CW-1:0]                 i_tpos,
    input  logic [CW-2:0]                        i_tsize,
    input  logic [swa_pkg::TS_W-1:0]             i_ts,
    output swa_pkg::t_slab                       o_slab,
    output logic signed [CW+swa_pkg::TS_W-1:0]   o_dir,
    output logic signed [CW-1:0]                 o_pos,
    output logic [CW-2:0]                        o_size
);
    import swa_pkg::*;

    localparam int NW  = CW + 2;
    localparam int DW  = CW + TS_W;
    localparam int DS  = TFB + 16;
    localparam int DL  = NW + DS + 1;
    localparam int SBW = 2 + DW + CW + CW - 1;

    logic signed [NW-1:0] n_dn, n_df, r_dn, r_df;
    logic signed [DW-1:0] n_dir;
    logic [SBW-1:0]       r_sb [DL+1];

    // Form slab edge offsets and the ray direction
    always_comb begin
        n_dn  = NW'(i_tpos) - NW'(i_pos) - $signed(NW'(i_size));
        n_df  = NW'(i_tpos) + $signed(NW'(i_tsize)) - NW'(i_pos);
        n_dir = i_vel * $signed({1'b0, i_ts});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dn     <= n_dn;
            r_df     <= n_df;
            r_sb[0]  <= {(i_vel == '0), (n_dn <= 0) && (n_df >= 0), n_dir, i_pos, i_size};
        end
    end

    // Carry side data along with the dividers
    genvar j;
    for (j = 1; j <= DL; j++) begin : g_sb
        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_sb[j] <= r_sb[j-1];
            end
        end
    end

    logic signed [31:0] q_near, q_far;

    logic signed [DW-1:0] n_dir_hold;
    assign n_dir_hold = $signed(r_sb[0][2*CW+DW-2:2*CW-1]);

    swa_div #(.NW(NW), .DW(DW), .DS(DS)) u_div_near (
        .i_clk (i_clk),
        .i_en  (i_en[DL:1]),
        .i_num (r_dn),
        .i_den (n_dir_hold),
        .o_quo (q_near)
    );

    swa_div #(.NW(NW), .DW(DW), .DS(DS)) u_div_far (
        .i_clk (i_clk),
        .i_en  (i_en[DL:1]),
        .i_num (r_df),
        .i_den (n_dir_hold),
        .o_quo (q_far)
    );

    // Unpack side data at the divider output
    logic                 sb_vz, sb_in;
    logic signed [DW-1:0] sb_dir;
    logic signed [CW-1:0] sb_pos;
    logic [CW-2:0]        sb_size;
    assign {sb_vz, sb_in, sb_dir, sb_pos, sb_size} = r_sb[DL];

    // Order the slab times, or open the slab for a still axis
    t_slab                n_slab;
    logic signed [TW-1:0] ta, tb;
    always_comb begin
        ta          = TW'(q_near);
        tb          = TW'(q_far);
        n_slab.vz   = sb_vz;
        n_slab.dneg = sb_dir[DW-1];
        if (sb_dir == '0) begin
            n_slab.ok = sb_in;
            n_slab.tn = -T_INF;
            n_slab.tf = T_INF;
        end else begin
            n_slab.ok = 1'b1;
            n_slab.tn = (ta > tb) ? tb : ta;
            n_slab.tf = (ta > tb) ? ta : tb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[DL+1]) begin
            o_slab <= n_slab;
            o_dir  <= sb_dir;
            o_pos  <= sb_pos;
            o_size <= sb_size;
        end
    end

endmodule

// ===== hw/rtl/swa_contact.sv =====
module swa_contact #(
    parameter int CW  = 24,
    parameter int TFB = 16
) (
    input  logic                                   i_clk,
    input  logic [1:0]                             i_en,
    input  logic signed [CW+swa_pkg::TS_W-1:0]     i_dir,
    input  logic signed [CW-1:0]                   i_pos,
    input  logic [CW-2:0]                          i_size,
    input  logic [TFB-1:0]                         i_t,
    output logic signed [CW+swa_pkg::TS_W+TFB:0]   o_v
);
    import swa_pkg::*;

    localparam int DW  = CW + TS_W;
    localparam int PW  = DW + TFB + 1;
    localparam int PHW = DW - SPLIT + TFB + 1;
    localparam int PLW = SPLIT + TFB;

    logic signed [PHW-1:0] r_ph;
    logic [PLW-1:0]        r_pl;
    logic signed [CW-1:0]  r_pos;
    logic [CW-2:0]         r_size;

    // Split the direction and multiply each half by the entry time
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ph   <= $signed(i_dir[DW-1:SPLIT]) * $signed({1'b0, i_t});
            r_pl   <= i_dir[SPLIT-1:0] * i_t;
            r_pos  <= i_pos;
            r_size <= i_size;
        end
    end

    // Join partial products, scale to Q.9 and add twice the origin
    logic signed [PW-1:0] full, scl, n_v;
    always_comb begin
        full = $signed({r_ph, {SPLIT{1'b0}}}) + $signed(PW'(r_pl));
        scl  = full >>> (TFB + 15);
        n_v  = (PW'(r_pos) <<< 1) + $signed(PW'(r_size)) + scl;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            o_v <= n_v;
        end
    end

endmodule

// ===== hw/rtl/swept_aabb_collision.sv =====
// Swept rectangle collision: one moving and one static axis-aligned rectangle
// go in on the input channel (i_valid / o_stall) as one item, and one result
// comes out on the output channel (o_valid / i_stall): hit flag, contact
// point, contact normal and entry time. A rejected query gives all zeros.
// The time step register is written through i_time_step_we / i_time_step;
// the user must write it only while no item is in flight; the block does not enforce this.
// One item is accepted every cycle while o_stall is low. The pipeline depth
// is set mostly by the restoring dividers in the two axis lanes, which retire
// one quotient bit per stage over COORD_WIDTH + TIME_FRAC_BITS + 18 stages.
// Stages advance independently: an empty stage takes the item behind it even
// when the output is stalled, so o_stall rises only once every stage is full
// and the receiver holds i_stall. The output holds while stalled.
// Reset empties the pipeline and sets the time step to 1.0.
module swept_aabb_collision #(
    parameter int COORD_WIDTH    = 24,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_time_step_we,
    input  logic [swa_pkg::TS_W-1:0]       i_time_step,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [COORD_WIDTH-1:0]  i_mover_x,
    input  logic signed [COORD_WIDTH-1:0]  i_mover_y,
    input  logic [COORD_WIDTH-2:0]         i_mover_width,
    input  logic [COORD_WIDTH-2:0]         i_mover_height,
    input  logic signed [COORD_WIDTH-1:0]  i_velocity_x,
    input  logic signed [COORD_WIDTH-1:0]  i_velocity_y,
    input  logic signed [COORD_WIDTH-1:0]  i_target_x,
    input  logic signed [COORD_WIDTH-1:0]  i_target_y,
    input  logic [COORD_WIDTH-2:0]         i_target_width,
    input  logic [COORD_WIDTH-2:0]         i_target_height,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit,
    output logic signed [31:0]             o_contact_x,
    output logic signed [31:0]             o_contact_y,
    output logic signed [1:0]              o_normal_x,
    output logic signed [1:0]              o_normal_y,
    output logic signed [31:0]             o_entry_time
);
    import swa_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int TFB  = TIME_FRAC_BITS;
    localparam int DW   = CW + TS_W;
    localparam int VW   = DW + TFB + 1;
    localparam int LLAT = CW + TFB + 21;
    localparam int N    = LLAT + 4;
    localparam logic signed [TW-1:0] T_ONE   = TW'(1) <<< TFB;
    localparam logic signed [31:0]   T_ONE32 = 32'(T_ONE);

    // Time step register
    logic [TS_W-1:0] r_ts;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= TS_W'(65536);
        end else if (i_time_step_we) begin
            r_ts <= i_time_step;
        end
    end

    // Stage valids and enables: a stage moves unless it and all after it are full
    logic [N-1:0] r_vld;
    logic [N-1:0] en;
    always_comb begin
        for (int k = 0; k < N; k++) begin
            en[k] = !(i_stall && ((r_vld >> k) == ({N{1'b1}} >> k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[N-1];

    // Axis lanes
    t_slab                sx, sy;
    logic signed [DW-1:0] dx, dy;
    logic signed [CW-1:0] px, py;
    logic [CW-2:0]        wx, wy;

    swa_lane #(.CW(CW), .TFB(TFB)) u_lane_x (
        .i_clk   (i_clk),
        .i_en    (en[LLAT-1:0]),
        .i_pos   (i_mover_x),
        .i_size  (i_mover_width),
        .i_vel   (i_velocity_x),
        .i_tpos  (i_target_x),
        .i_tsize (i_target_width),
        .i_ts    (r_ts),
        .o_slab  (sx),
        .o_dir   (dx),
        .o_pos   (px),
        .o_size  (wx)
    );

    swa_lane #(.CW(CW), .TFB(TFB)) u_lane_y (
        .i_clk   (i_clk),
        .i_en    (en[LLAT-1:0]),
        .i_pos   (i_mover_y),
        .i_size  (i_mover_height),
        .i_vel   (i_velocity_y),
        .i_tpos  (i_target_y),
        .i_tsize (i_target_height),
        .i_ts    (r_ts),
        .o_slab  (sy),
        .o_dir   (dy),
        .o_pos   (py),
        .o_size  (wy)
    );

    // Merge the two slabs: reject, pick entry time and normal
    logic                 n_hit;
    logic signed [TW-1:0] tnear, tfar;
    logic signed [1:0]    n_nx, n_ny;
    always_comb begin
        tnear = (sx.tn > sy.tn) ? sx.tn : sy.tn;
        tfar  = (sx.tf < sy.tf) ? sx.tf : sy.tf;
        n_hit = !(sx.vz && sy.vz) && sx.ok && sy.ok
                && !(sx.tn > sy.tf) && !(sy.tn > sx.tf)
                && !(tfar < 0) && !(tnear < 0) && (tnear < T_ONE);
        if (sx.tn > sy.tn) begin
            n_nx = sx.dneg ? NRM_POS : NRM_NEG;
            n_ny = NRM_ZERO;
        end else if (sx.tn < sy.tn) begin
            n_nx = NRM_ZERO;
            n_ny = sy.dneg ? NRM_POS : NRM_NEG;
        end else begin
            n_nx = sx.dneg ? NRM_NEG : NRM_POS;
            n_ny = sy.dneg ? NRM_NEG : NRM_POS;
        end
    end

    logic                 r_mg_hit;
    logic signed [31:0]   r_mg_t;
    logic signed [1:0]    r_mg_nx, r_mg_ny;
    logic signed [DW-1:0] r_mg_dx, r_mg_dy;
    logic signed [CW-1:0] r_mg_px, r_mg_py;
    logic [CW-2:0]        r_mg_wx, r_mg_wy;

    always_ff @(posedge i_clk) begin
        if (en[LLAT]) begin
            r_mg_hit <= n_hit;
            r_mg_t   <= tnear[31:0];
            r_mg_nx  <= n_nx;
            r_mg_ny  <= n_ny;
            r_mg_dx  <= dx;
            r_mg_dy  <= dy;
            r_mg_px  <= px;
            r_mg_py  <= py;
            r_mg_wx  <= wx;
            r_mg_wy  <= wy;
        end
    end

    // Contact point per axis
    logic signed [VW-1:0] vx, vy;

    swa_contact #(.CW(CW), .TFB(TFB)) u_contact_x (
        .i_clk  (i_clk),
        .i_en   (en[LLAT+2:LLAT+1]),
        .i_dir  (r_mg_dx),
        .i_pos  (r_mg_px),
        .i_size (r_mg_wx),
        .i_t    (r_mg_t[TFB-1:0]),
        .o_v    (vx)
    );

    swa_contact #(.CW(CW), .TFB(TFB)) u_contact_y (
        .i_clk  (i_clk),
        .i_en   (en[LLAT+2:LLAT+1]),
        .i_dir  (r_mg_dy),
        .i_pos  (r_mg_py),
        .i_size (r_mg_wy),
        .i_t    (r_mg_t[TFB-1:0]),
        .o_v    (vy)
    );

    // Hold merge results alongside the contact stages
    logic               r_c1_hit, r_c2_hit;
    logic signed [31:0] r_c1_t, r_c2_t;
    logic signed [1:0]  r_c1_nx, r_c1_ny, r_c2_nx, r_c2_ny;

    always_ff @(posedge i_clk) begin
        if (en[LLAT+1]) begin
            r_c1_hit <= r_mg_hit;
            r_c1_t   <= r_mg_t;
            r_c1_nx  <= r_mg_nx;
            r_c1_ny  <= r_mg_ny;
        end
        if (en[LLAT+2]) begin
            r_c2_hit <= r_c1_hit;
            r_c2_t   <= r_c1_t;
            r_c2_nx  <= r_c1_nx;
            r_c2_ny  <= r_c1_ny;
        end
    end

    // Halve Q.9 to Q.8 rounding down, then clamp to 32 bits
    function automatic logic signed [31:0] f_sat(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] h;
        h = v >>> 1;
        if (h > VW'(S32_MAX)) begin
            return S32_MAX;
        end else if (h < VW'(S32_MIN)) begin
            return S32_MIN;
        end
        return h[31:0];
    endfunction

    // Output register; zero everything on rejection
    always_ff @(posedge i_clk) begin
        if (en[N-1]) begin
            o_hit        <= r_c2_hit;
            o_contact_x  <= r_c2_hit ? f_sat(vx) : '0;
            o_contact_y  <= r_c2_hit ? f_sat(vy) : '0;
            o_normal_x   <= r_c2_hit ? r_c2_nx : NRM_ZERO;
            o_normal_y   <= r_c2_hit ? r_c2_ny : NRM_ZERO;
            o_entry_time <= r_c2_hit ? r_c2_t : '0;
        end
    end

`ifndef ASSERT_OFF
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_contact_x == '0 && o_contact_y == '0
            && o_normal_x == NRM_ZERO && o_normal_y == NRM_ZERO && o_entry_time == '0))
        else $error("rejected item carries nonzero fields");

    a_hit_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_entry_time >= 0 && o_entry_time < T_ONE32))
        else $error("hit with entry time outside the step");

    a_hit_nrm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_normal_x != NRM_ZERO || o_normal_y != NRM_ZERO))
        else $error("hit without contact normal");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage is empty");
`endif

endmodule

// ===== tb/swept_aabb_collision_test.sv =====
module swept_aabb_collision_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swa_pkg::*;

    localparam int CW = 24;
    localparam logic [TS_W-1:0] STEP_ONE = 24'd65536;

    typedef struct {
        logic signed [CW-1:0] mx, my, vx, vy, tx, ty;
        logic [CW-2:0]        mw, mh, tw, th;
    } t_query;

    typedef struct {
        logic              hit;
        logic signed [31:0] cx, cy;
        logic signed [1:0]  nx, ny;
        logic signed [31:0] tm;
    } t_contact;

    typedef struct {
        t_query   q;
        logic     typed;   // expected result given in the row
        t_contact res;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_time_step_we;
    logic [TS_W-1:0] i_time_step;
    logic i_valid, o_stall, o_valid;
    logic i_stall = 1'b0;
    logic signed [CW-1:0] i_mover_x, i_mover_y, i_velocity_x, i_velocity_y;
    logic signed [CW-1:0] i_target_x, i_target_y;
    logic [CW-2:0] i_mover_width, i_mover_height, i_target_width, i_target_height;
    logic o_hit;
    logic signed [31:0] o_contact_x, o_contact_y, o_entry_time;
    logic signed [1:0] o_normal_x, o_normal_y;

    logic [TS_W-1:0] step_reg;
    t_contact contacts_due[$];
    int fails;
    int stall_mode = 0;

    swept_aabb_collision u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_time_step_we(i_time_step_we), .i_time_step(i_time_step),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_mover_x(i_mover_x), .i_mover_y(i_mover_y),
        .i_mover_width(i_mover_width), .i_mover_height(i_mover_height),
        .i_velocity_x(i_velocity_x), .i_velocity_y(i_velocity_y),
        .i_target_x(i_target_x), .i_target_y(i_target_y),
        .i_target_width(i_target_width), .i_target_height(i_target_height),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_hit(o_hit), .o_contact_x(o_contact_x), .o_contact_y(o_contact_y),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y),
        .o_entry_time(o_entry_time)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // floor division on wide signed values
    function automatic logic signed [127:0] floor_div(logic signed [127:0] a,
                                                      logic signed [127:0] b);
        logic signed [127:0] q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic longint sat32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 64'sd2147483647;
        if (v < -128'sd2147483648) return -64'sd2147483648;
        return longint'(v);
    endfunction

    // entry/exit times of one slab; zero direction limits nothing if inside
    function automatic bit slab_times(longint dn, longint df, longint dir,
                                      output longint tn, output longint tf);
        longint s;
        if (dir == 0) begin
            tn = -(longint'(1) <<< 40);
            tf = longint'(1) <<< 40;
            return dn <= 0 && df >= 0;
        end
        tn = sat32(floor_div(128'(dn) <<< 32, 128'(dir)));
        tf = sat32(floor_div(128'(df) <<< 32, 128'(dir)));
        if (tn > tf) begin
            s = tn; tn = tf; tf = s;
        end
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] contact_pos(longint pos, longint size,
                                                       longint dir, longint t);
        logic signed [127:0] v;
        v = 2 * 128'(pos) + 128'(size) + floor_div(128'(dir) * 128'(t), 128'sd1 <<< 31);
        return 32'(sat32(floor_div(v, 128'sd2)));
    endfunction

    function automatic t_contact sweep_contact(t_query q, logic [TS_W-1:0] step);
        t_contact r;
        longint mx, my, mw, mh, vx, vy, tx, ty, tw, th, dx, dy;
        longint nx, fx, ny, fy, tnear, tfar;
        r = '{default: '0};
        mx = q.mx; my = q.my; vx = q.vx; vy = q.vy; tx = q.tx; ty = q.ty;
        mw = longint'({1'b0, q.mw}); mh = longint'({1'b0, q.mh});
        tw = longint'({1'b0, q.tw}); th = longint'({1'b0, q.th});
        dx = vx * longint'({1'b0, step});
        dy = vy * longint'({1'b0, step});
        if (vx == 0 && vy == 0) return r;
        if (!slab_times(tx - mx - mw, tx + tw - mx, dx, nx, fx)) return r;
        if (!slab_times(ty - my - mh, ty + th - my, dy, ny, fy)) return r;
        if (nx > fy || ny > fx) return r;
        tnear = (nx > ny) ? nx : ny;
        tfar = (fx < fy) ? fx : fy;
        if (tfar < 0) return r;
        if (tnear < 0 || tnear >= 65536) return r;
        r.nx = NRM_ZERO;
        r.ny = NRM_ZERO;
        if (nx > ny) begin
            r.nx = (dx < 0) ? NRM_POS : NRM_NEG;
        end else if (nx < ny) begin
            r.ny = (dy < 0) ? NRM_POS : NRM_NEG;
        end else begin
            r.nx = (dx < 0) ? NRM_NEG : NRM_POS;
            r.ny = (dy < 0) ? NRM_NEG : NRM_POS;
        end
        r.hit = 1'b1;
        r.cx = contact_pos(mx, mw, dx, tnear);
        r.cy = contact_pos(my, mh, dy, tnear);
        r.tm = 32'(tnear);
        return r;
    endfunction

    // present one item and hold it until accepted
    task automatic send_query(t_query q, bit typed, t_contact res);
        i_valid <= 1'b1;
        i_mover_x <= q.mx; i_mover_y <= q.my;
        i_mover_width <= q.mw; i_mover_height <= q.mh;
        i_velocity_x <= q.vx; i_velocity_y <= q.vy;
        i_target_x <= q.tx; i_target_y <= q.ty;
        i_target_width <= q.tw; i_target_height <= q.th;
        do @(posedge i_clk); while (o_stall);
        contacts_due.push_back(typed ? res : sweep_contact(q, step_reg));
    endtask

    task automatic idle_cycles(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // wait until every expected item is back, then let the pipe settle
    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (contacts_due.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_step(logic [TS_W-1:0] v);
        i_time_step_we <= 1'b1;
        i_time_step <= v;
        @(posedge i_clk);
        i_time_step_we <= 1'b0;
        step_reg = v;
    endtask

    function automatic t_query rand_query();
        t_query q;
        if ($urandom_range(0, 3) == 0) begin
            // anything the fields allow
            q.mx = CW'($urandom); q.my = CW'($urandom);
            q.vx = CW'($urandom); q.vy = CW'($urandom);
            q.tx = CW'($urandom); q.ty = CW'($urandom);
            q.mw = (CW-1)'($urandom); q.mh = (CW-1)'($urandom);
            q.tw = (CW-1)'($urandom); q.th = (CW-1)'($urandom);
        end else begin
            // near pair with motion toward the target
            q.mx = CW'($signed($urandom_range(0, 8192)) - 4096);
            q.my = CW'($signed($urandom_range(0, 8192)) - 4096);
            q.mw = (CW-1)'($urandom_range(0, 1024));
            q.mh = (CW-1)'($urandom_range(0, 1024));
            q.tx = CW'(q.mx + $signed($urandom_range(0, 6000)) - 3000);
            q.ty = CW'(q.my + $signed($urandom_range(0, 6000)) - 3000);
            q.tw = (CW-1)'($urandom_range(0, 2048));
            q.th = (CW-1)'($urandom_range(0, 2048));
            q.vx = CW'((q.tx - q.mx) + $signed($urandom_range(0, 800)) - 400);
            q.vy = CW'((q.ty - q.my) + $signed($urandom_range(0, 800)) - 400);
            case ($urandom_range(0, 5))
                0: q.vx = '0;
                1: q.vy = '0;
                2: q.vy = CW'(q.vx * (q.ty - q.my)
                              / ((q.tx - q.mx) == 0 ? 1 : (q.tx - q.mx)));
                default: ;
            endcase
        end
        return q;
    endfunction

    // receiver stall pattern, mode changes every so often
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // compare each delivered item with the oldest expectation
    always @(posedge i_clk) begin
        t_contact e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (contacts_due.size() == 0) begin
                $error("result item with nothing expected");
                fails++;
            end else begin
                e = contacts_due.pop_front();
                if (o_hit !== e.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, o_hit); fails++;
                end
                if (o_contact_x !== e.cx) begin
                    $error("contact_x: expected %0d, got %0d", e.cx, o_contact_x); fails++;
                end
                if (o_contact_y !== e.cy) begin
                    $error("contact_y: expected %0d, got %0d", e.cy, o_contact_y); fails++;
                end
                if (o_normal_x !== e.nx) begin
                    $error("normal_x: expected %0d, got %0d", e.nx, o_normal_x); fails++;
                end
                if (o_normal_y !== e.ny) begin
                    $error("normal_y: expected %0d, got %0d", e.ny, o_normal_y); fails++;
                end
                if (o_entry_time !== e.tm) begin
                    $error("entry_time: expected %0d, got %0d", e.tm, o_entry_time);
                    fails++;
                end
            end
        end
    end

    initial begin
        #4ms;
        $display("[swept_aabb_collision] ERROR");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_row r;
        t_contact zero_res, side_hit;
        logic [TS_W-1:0] steps[6];
        int n, burst;

        step_reg = STEP_ONE;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_time_step_we = 1'b0;
        i_time_step = '0;
        {i_mover_x, i_mover_y, i_velocity_x, i_velocity_y, i_target_x, i_target_y} = '0;
        {i_mover_width, i_mover_height, i_target_width, i_target_height} = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        zero_res = '{default: '0};
        side_hit = '{hit: 1'b1, cx: 384, cy: 128, nx: NRM_NEG, ny: NRM_ZERO, tm: 16384};

        // directed rows: mover, size, velocity, target, size
        r.typed = 1'b1; r.res = zero_res;
        r.q = '{mx: 0, my: 0, vx: 0, vy: 0, tx: 0, ty: 0, mw: 256, mh: 256, tw: 256, th: 256};
        rows.push_back(r);                       // no motion
        r.res = side_hit;
        r.q = '{mx: 0, my: 0, vx: 1024, vy: 0, tx: 512, ty: 0,
                mw: 256, mh: 256, tw: 256, th: 256};
        rows.push_back(r);                       // side entry at a quarter step
        r.res = zero_res;
        r.q.ty = 24'sd4096;
        rows.push_back(r);                       // zero y direction outside slab
        r.typed = 1'b0;
        r.q = '{mx: 0, my: 0, vx: 1024, vy: 1024, tx: 512, ty: 512,
                mw: 256, mh: 256, tw: 256, th: 256};
        rows.push_back(r);                       // diagonal entry
        r.q.vx = -24'sd1024; r.q.vy = -24'sd1024; r.q.tx = -24'sd768; r.q.ty = -24'sd768;
        rows.push_back(r);                       // diagonal from the other side
        r.q = '{mx: 0, my: 0, vx: 0, vy: -2048, tx: 0, ty: -1024,
                mw: 256, mh: 256, tw: 256, th: 256};
        rows.push_back(r);                       // y dominance, upward
        r.q = '{mx: 0, my: 0, vx: -4096, vy: 100, tx: -2048, ty: 0,
                mw: 256, mh: 256, tw: 256, th: 256};
        rows.push_back(r);                       // x dominance, leftward
        r.q = '{mx: 0, my: 0, vx: 512, vy: 0, tx: 100, ty: 0,
                mw: 256, mh: 256, tw: 256, th: 256};
        rows.push_back(r);                       // already overlapping
        r.q.tx = -24'sd2048;
        rows.push_back(r);                       // target behind
        r.q = '{mx: 24'sh7fffff, my: 24'sh7fffff, vx: 24'sh800000, vy: 24'sh800000,
                tx: 24'sh800000, ty: 24'sh800000, mw: 23'h7fffff, mh: 23'h7fffff,
                tw: 23'h7fffff, th: 23'h7fffff};
        rows.push_back(r);
        r.q = '{mx: 24'sh800000, my: 24'sh800000, vx: 24'sh7fffff, vy: 24'sh7fffff,
                tx: 24'sh7fffff, ty: 24'sh7fffff, mw: 0, mh: 0, tw: 0, th: 0};
        rows.push_back(r);
        r.q = '{mx: 24'sh800000, my: 0, vx: 24'sh7fffff, vy: 1, tx: 24'sh7fffff, ty: 0,
                mw: 23'h7fffff, mh: 23'h7fffff, tw: 23'h7fffff, th: 23'h7fffff};
        rows.push_back(r);                       // far entry time, saturating ranges
        r.q = '{mx: 0, my: 0, vx: 1, vy: 0, tx: 256, ty: 0, mw: 0, mh: 0, tw: 0, th: 0};
        rows.push_back(r);                       // slow mover, entry well past the step

        foreach (rows[i])
            send_query(rows[i].q, rows[i].typed, rows[i].res);
        drain();

        // step settings for the random phases, extremes among them
        steps[0] = STEP_ONE;
        steps[1] = '0;
        steps[2] = 24'hffffff;
        steps[3] = 24'd1;
        steps[4] = TS_W'($urandom_range(1024, 262144));
        steps[5] = 24'd32768;
        foreach (steps[p]) begin
            write_step(steps[p]);
            n = 0;
            while (n < 250) begin
                burst = $urandom_range(1, 40);
                repeat (burst) begin
                    send_query(rand_query(), 1'b0, zero_res);
                    n++;
                end
                if ($urandom_range(0, 2) != 0)
                    idle_cycles($urandom_range(1, 12));
                if (n > 130 && n < 170 && p == 2)
                    drain();
            end
            drain();
        end

        if (fails == 0 && contacts_due.size() == 0) begin
            $display("[swept_aabb_collision] OK");
        end else begin
            $display("[swept_aabb_collision] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/swa_pkg.sv
hw/rtl/swa_div.sv
hw/rtl/swa_lane.sv
hw/rtl/swa_contact.sv
hw/rtl/swept_aabb_collision.sv
tb/swept_aabb_collision_test.sv
